/* sv/kvlp_pkg.sv */
// Shared types, codes and character classes for the key/value line parser.
package kvlp_pkg;

   typedef enum logic [3:0] {
      PH_SEARCH_KEY = 4'd0,
      PH_IN_KEY     = 4'd1,
      PH_SEARCH_SEP = 4'd2,
      PH_SEARCH_VAL = 4'd3,
      PH_IN_VALUE   = 4'd4,
      PH_IN_QUOTE   = 4'd5,
      PH_IN_ESCAPE  = 4'd6,
      PH_SEARCH_END = 4'd7,
      PH_COMMENT    = 4'd8,
      PH_ERROR      = 4'd9
   } phase_type;

   localparam logic [1:0] KIND_KEY      = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_LINE_END = 2'd2;

   localparam logic [1:0] CLS_STRING = 2'd0;
   localparam logic [1:0] CLS_INT    = 2'd1;
   localparam logic [1:0] CLS_DOUBLE = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_KEY     = 3'd1;
   localparam logic [2:0] ST_BAD_KEY    = 3'd2;
   localparam logic [2:0] ST_NO_COLON   = 3'd3;
   localparam logic [2:0] ST_NO_VALUE   = 3'd4;
   localparam logic [2:0] ST_STRAY      = 3'd5;
   localparam logic [2:0] ST_OPEN_QUOTE = 3'd6;
   localparam logic [2:0] ST_EMPTY      = 3'd7;

   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D && b != CH_LF);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_key_char(input logic [7:0] b);
      return is_digit(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
             (b == CH_UNDERSCORE) || (b == CH_DASH);
   endfunction

   // Class after one more value byte; present means a value byte came before.
   function automatic logic [1:0] class_update(input logic [1:0] cls,
                                               input logic [7:0] b,
                                               input logic present);
      logic [1:0] res;
      res = cls;
      if (cls == CLS_INT && b == CH_DOT) begin
         res = CLS_DOUBLE;
      end else if (cls != CLS_STRING) begin
         if ((cls == CLS_DOUBLE && b == CH_DOT) ||
             (!is_digit(b) && b != CH_DOT && b != CH_DASH) ||
             (b == CH_DASH && present)) begin
            res = CLS_STRING;
         end
      end
      return res;
   endfunction

endpackage

/* sv/key_value_line_parser.sv */
// Key/value line parser: one text byte per beat in, key/value bytes and line ends out.
//
// chan | dir | handshake           | fields (port = chan_field)
// req  | in  | req_valid req_stall | char_in stream_end
// rsp  | out | rsp_valid rsp_stall | item_kind byte_out escape_prefix line_status value_class
//
// One byte per cycle unless stalled. A beat is parsed in the cycle it is
// accepted and its result, if any, sits in the output register from the next cycle on.
// Reset (synchronous) puts the parser at the start of a line with no
// result pending. req_stall follows rsp_stall while a result waits, so the
// input stalls only when the output register is full and not being taken.
module key_value_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_item_kind,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_escape_prefix,
   output logic [2:0] rsp_line_status,
   output logic [1:0] rsp_value_class
);
   import kvlp_pkg::*;

   // per-line parser state
   phase_type  phase_ff, phase_in;
   logic [2:0] error_kind_ff, error_kind_in;
   logic       quoted_seen_ff, quoted_seen_in;
   logic       key_present_ff, key_present_in;
   logic       value_present_ff, value_present_in;
   logic [1:0] class_ff, class_in;
   logic       line_open_ff, line_open_in;

   // output register
   logic       rsp_valid_ff;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       esc_ff, esc_in;
   logic [2:0] status_ff, status_in;
   logic [1:0] vclass_ff, vclass_in;
   logic       res_fire;

   logic       req_fire;
   logic       out_free;
   logic       take_key;
   logic       take_value;
   logic       value_esc;
   logic [7:0] b;

   // The output register can be loaded when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign req_fire  = req_valid && out_free;
   assign b         = req_char_in;

   always_comb begin
      phase_in         = phase_ff;
      error_kind_in    = error_kind_ff;
      quoted_seen_in   = quoted_seen_ff;
      key_present_in   = key_present_ff;
      value_present_in = value_present_ff;
      class_in         = class_ff;
      line_open_in     = line_open_ff;
      res_fire         = 1'b0;
      kind_in          = KIND_KEY;
      byte_in          = 8'h00;
      esc_in           = 1'b0;
      status_in        = ST_OK;
      vclass_in        = CLS_STRING;
      take_key         = 1'b0;
      take_value       = 1'b0;
      value_esc        = 1'b0;

      priority if (req_stream_end || b == CH_LF) begin
         // stream end closes a line only if one is open; newline always does
         if (!req_stream_end || line_open_ff) begin
            res_fire = 1'b1;
            kind_in  = KIND_LINE_END;
            priority if (phase_ff == PH_ERROR)       status_in = error_kind_ff;
            else if (phase_ff == PH_IN_QUOTE)        status_in = ST_OPEN_QUOTE;
            else if (!key_present_ff)                status_in = ST_NO_KEY;
            else if (!quoted_seen_ff && !value_present_ff) status_in = ST_EMPTY;
            else                                     status_in = ST_OK;
            vclass_in = (quoted_seen_ff || !value_present_ff) ? CLS_STRING : class_ff;
            phase_in         = PH_SEARCH_KEY;
            error_kind_in    = ST_OK;
            quoted_seen_in   = 1'b0;
            key_present_in   = 1'b0;
            value_present_in = 1'b0;
            class_in         = CLS_INT;
            line_open_in     = 1'b0;
         end
      end else begin
         line_open_in = 1'b1;
         unique case (phase_ff)
            PH_SEARCH_KEY: begin
               priority if (b == CH_HASH) phase_in = PH_COMMENT;
               else if (is_key_char(b)) begin
                  phase_in = PH_IN_KEY;
                  take_key = 1'b1;
               end else if (!is_ws(b)) begin
                  phase_in      = PH_ERROR;
                  error_kind_in = ST_BAD_KEY;
               end
            end
            PH_IN_KEY: begin
               priority if (b == CH_COLON) phase_in = PH_SEARCH_VAL;
               else if (is_ws(b))          phase_in = PH_SEARCH_SEP;
               else if (is_key_char(b))    take_key = 1'b1;
               else begin
                  phase_in      = PH_ERROR;
                  error_kind_in = ST_BAD_KEY;
               end
            end
            PH_SEARCH_SEP: begin
               priority if (b == CH_COLON) phase_in = PH_SEARCH_VAL;
               else if (!is_ws(b)) begin
                  phase_in      = PH_ERROR;
                  error_kind_in = ST_NO_COLON;
               end
            end
            PH_SEARCH_VAL: begin
               priority if (b == CH_HASH) begin
                  phase_in      = PH_ERROR;
                  error_kind_in = ST_NO_VALUE;
               end else if (b == CH_QUOTE) begin
                  phase_in = PH_IN_QUOTE;
               end else if (!is_ws(b)) begin
                  phase_in   = PH_IN_VALUE;
                  take_value = 1'b1;
               end
            end
            PH_IN_VALUE: begin
               priority if (b == CH_HASH) phase_in = PH_COMMENT;
               else if (is_ws(b))         phase_in = PH_SEARCH_END;
               else                       take_value = 1'b1;
            end
            PH_IN_QUOTE: begin
               quoted_seen_in = 1'b1;
               priority if (b == CH_QUOTE)  phase_in = PH_SEARCH_END;
               else if (b == CH_BACKSLASH)  phase_in = PH_IN_ESCAPE;
               else                         take_value = 1'b1;
            end
            PH_IN_ESCAPE: begin
               // a doubled backslash stays in the escape
               take_value = 1'b1;
               if (b != CH_BACKSLASH) begin
                  phase_in  = PH_IN_QUOTE;
                  value_esc = (b != CH_QUOTE);
               end
            end
            PH_SEARCH_END: begin
               priority if (b == CH_HASH) phase_in = PH_COMMENT;
               else if (!is_ws(b)) begin
                  phase_in      = PH_ERROR;
                  error_kind_in = ST_STRAY;
               end
            end
            default: ; // comment and error phases drop the rest of the line
         endcase

         if (take_key) begin
            res_fire       = 1'b1;
            kind_in        = KIND_KEY;
            byte_in        = b;
            key_present_in = 1'b1;
         end
         if (take_value) begin
            res_fire         = 1'b1;
            kind_in          = KIND_VALUE;
            byte_in          = b;
            esc_in           = value_esc;
            class_in         = class_update(class_ff, b, value_present_ff);
            value_present_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SEARCH_KEY;
         error_kind_ff    <= ST_OK;
         quoted_seen_ff   <= 1'b0;
         key_present_ff   <= 1'b0;
         value_present_ff <= 1'b0;
         class_ff         <= CLS_INT;
         line_open_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff         <= phase_in;
            error_kind_ff    <= error_kind_in;
            quoted_seen_ff   <= quoted_seen_in;
            key_present_ff   <= key_present_in;
            value_present_ff <= value_present_in;
            class_ff         <= class_in;
            line_open_ff     <= line_open_in;
         end
         if (out_free) begin
            rsp_valid_ff <= req_fire && res_fire;
         end
      end
   end

   // payload of the output register, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && res_fire) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         esc_ff    <= esc_in;
         status_ff <= status_in;
         vclass_ff <= vclass_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_kind     = kind_ff;
   assign rsp_byte_out      = byte_ff;
   assign rsp_escape_prefix = esc_ff;
   assign rsp_line_status   = status_ff;
   assign rsp_value_class   = vclass_ff;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for key_value_line_parser: directed lines, then random text.
`timescale 1ns / 1ps

module tb_top;
   import kvlp_pkg::*;

   // Set many times over the worst case for the whole run.
   localparam int CYCLE_LIMIT  = 200000;
   // Output is one register deep; the extra drain covers anything still in flight.
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_REPORTS  = 10;

   // One parser output beat, field by field.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       esc;
      logic [2:0] status;
      logic [1:0] cls;
   } parse_item_type;

   // ---------------------------------------------------------------- DUT wiring
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in    = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [1:0] rsp_item_kind;
   logic [7:0] rsp_byte_out;
   logic       rsp_escape_prefix;
   logic [2:0] rsp_line_status;
   logic [1:0] rsp_value_class;

   key_value_line_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_in       (req_char_in),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_escape_prefix (rsp_escape_prefix),
      .rsp_line_status   (rsp_line_status),
      .rsp_value_class   (rsp_value_class)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- bookkeeping
   parse_item_type pending_items[$];  // predicted beats not yet seen on rsp
   int          cycle_count    = 0;
   int          sent_beats     = 0;
   int          checked_beats  = 0;
   int          lines_closed   = 0;
   int          mismatches     = 0;
   int          status_tally[8];
   logic        send_idle      = 1'b1;   // sender inserts random gaps
   logic        take_idle      = 1'b1;   // receiver inserts random stalls

   // ---------------------------------------------------------------- line predictor
   // Private copy of the parser state; updated once per accepted input beat.
   phase_type   cur_phase;
   logic [2:0]  fault_code;
   logic        quote_taken;
   logic        key_seen;
   logic        value_seen;
   logic [1:0]  num_class;
   logic        line_busy;

   function automatic logic blank_byte(input logic [7:0] b);
      return b == CH_SPACE || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
   endfunction

   function automatic logic num_byte(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic name_byte(input logic [7:0] b);
      return num_byte(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == CH_UNDERSCORE || b == CH_DASH;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic esc, input logic [2:0] status,
                                       input logic [1:0] cls);
      parse_item_type it;
      it.kind   = kind;
      it.data   = data;
      it.esc    = esc;
      it.status = status;
      it.cls    = cls;
      pending_items.push_back(it);
   endfunction

   function automatic void clear_line();
      cur_phase   = PH_SEARCH_KEY;
      fault_code  = ST_OK;
      quote_taken = 1'b0;
      key_seen    = 1'b0;
      value_seen  = 1'b0;
      num_class   = CLS_INT;
      line_busy   = 1'b0;
   endfunction

   function automatic void fail_line(input logic [2:0] code);
      fault_code = code;
      cur_phase  = PH_ERROR;
   endfunction

   function automatic void take_key(input logic [7:0] b);
      key_seen = 1'b1;
      push_result(KIND_KEY, b, 1'b0, ST_OK, CLS_STRING);
   endfunction

   // Integer until a dot, then double; string on a non-numeric byte, a second dot or a dash past the first byte.
   function automatic void take_value(input logic [7:0] b, input logic esc);
      if (num_class == CLS_INT && b == CH_DOT) begin
         num_class = CLS_DOUBLE;
      end else if (num_class != CLS_STRING) begin
         if ((num_class == CLS_DOUBLE && b == CH_DOT) ||
             (!num_byte(b) && b != CH_DOT && b != CH_DASH) ||
             (b == CH_DASH && value_seen)) begin
            num_class = CLS_STRING;
         end
      end
      value_seen = 1'b1;
      push_result(KIND_VALUE, b, esc, ST_OK, CLS_STRING);
   endfunction

   // Error first, then open quote, then missing key, then empty bare value.
   function automatic void close_line();
      logic [2:0] st;
      logic [1:0] cls;
      if (cur_phase == PH_ERROR)
         st = fault_code;
      else if (cur_phase == PH_IN_QUOTE)
         st = ST_OPEN_QUOTE;
      else if (!key_seen)
         st = ST_NO_KEY;
      else if (!quote_taken && !value_seen)
         st = ST_EMPTY;
      else
         st = ST_OK;
      cls = (quote_taken || !value_seen) ? CLS_STRING : num_class;
      status_tally[st]++;
      lines_closed++;
      clear_line();
      push_result(KIND_LINE_END, 8'h00, 1'b0, st, cls);
   endfunction

   function automatic void parse_char(input logic [7:0] b, input logic fin);
      if (fin) begin
         if (line_busy)
            close_line();
         return;
      end
      if (b == CH_LF) begin
         close_line();
         return;
      end
      line_busy = 1'b1;
      case (cur_phase)
         PH_SEARCH_KEY: begin
            if (b == CH_HASH)
               cur_phase = PH_COMMENT;
            else if (name_byte(b)) begin
               cur_phase = PH_IN_KEY;
               take_key(b);
            end else if (!blank_byte(b))
               fail_line(ST_BAD_KEY);
         end
         PH_IN_KEY: begin
            if (b == CH_COLON)
               cur_phase = PH_SEARCH_VAL;
            else if (blank_byte(b))
               cur_phase = PH_SEARCH_SEP;
            else if (name_byte(b))
               take_key(b);
            else
               fail_line(ST_BAD_KEY);
         end
         PH_SEARCH_SEP: begin
            if (b == CH_COLON)
               cur_phase = PH_SEARCH_VAL;
            else if (!blank_byte(b))
               fail_line(ST_NO_COLON);
         end
         PH_SEARCH_VAL: begin
            if (b == CH_HASH)
               fail_line(ST_NO_VALUE);
            else if (b == CH_QUOTE)
               cur_phase = PH_IN_QUOTE;
            else if (!blank_byte(b)) begin
               cur_phase = PH_IN_VALUE;
               take_value(b, 1'b0);
            end
         end
         PH_IN_VALUE: begin
            if (b == CH_HASH)
               cur_phase = PH_COMMENT;
            else if (blank_byte(b))
               cur_phase = PH_SEARCH_END;
            else
               take_value(b, 1'b0);
         end
         PH_IN_QUOTE: begin
            // any byte after the opening quote marks the line as quoted
            quote_taken = 1'b1;
            if (b == CH_QUOTE)
               cur_phase = PH_SEARCH_END;
            else if (b == CH_BACKSLASH)
               cur_phase = PH_IN_ESCAPE;
            else
               take_value(b, 1'b0);
         end
         PH_IN_ESCAPE: begin
            // double backslash emits one and stays in the escape
            if (b == CH_BACKSLASH)
               take_value(b, 1'b0);
            else begin
               cur_phase = PH_IN_QUOTE;
               take_value(b, b != CH_QUOTE);
            end
         end
         PH_SEARCH_END: begin
            if (b == CH_HASH)
               cur_phase = PH_COMMENT;
            else if (!blank_byte(b))
               fail_line(ST_STRAY);
         end
         default: ;   // comment and error phases swallow the rest of the line
      endcase
   endfunction

   // ---------------------------------------------------------------- result checker
   task automatic check_result();
      parse_item_type want;
      if (pending_items.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected beat: kind %0d byte %02h esc %0d %s %0d %s %0d",
                     $realtime, rsp_item_kind, rsp_byte_out, rsp_escape_prefix,
                     "status", rsp_line_status, "class", rsp_value_class);
         return;
      end
      want = pending_items.pop_front();
      checked_beats++;
      if (rsp_item_kind !== want.kind || rsp_byte_out !== want.data ||
          rsp_escape_prefix !== want.esc || rsp_line_status !== want.status ||
          rsp_value_class !== want.cls) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp kind %0d byte %02h esc %0d status %0d class %0d,",
                     $realtime, want.kind, want.data, want.esc, want.status, want.cls);
            $display("          got kind %0d byte %02h esc %0d status %0d class %0d",
                     rsp_item_kind, rsp_byte_out, rsp_escape_prefix, rsp_line_status,
                     rsp_value_class);
         end
      end
   endtask

   // Takes a beat whenever valid and not stalled, then stalls for a random while when take_idle is set.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
            stall_left = take_idle ? $urandom_range(0, 6) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) cycle_count++;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, pending_items.size());
      $display("key_value_line_parser regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus helpers
   // Called at a rising edge; returns at the edge where the beat is accepted.
   task automatic send_beat(input logic [7:0] ch, input logic fin);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_in    <= ch;
      req_stream_end <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_beats++;
      parse_char(ch, fin);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], 1'b0);
   endtask

   // Holds the input idle until every predicted beat has come out.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_items.size() != 0);
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 4))
         0: return 8'h09;
         1: return 8'h0B;
         2: return 8'h0C;
         3: return 8'h0D;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] name_char();
      int r;
      r = $urandom_range(0, 63);
      if (r < 10) return 8'(r + 8'h30);
      if (r < 36) return 8'(r - 10 + 8'h41);
      if (r < 62) return 8'(r - 36 + 8'h61);
      return (r == 62) ? CH_UNDERSCORE : CH_DASH;
   endfunction

   function automatic logic [7:0] num_char();
      int r;
      r = $urandom_range(0, 11);
      if (r < 10) return 8'(r + 8'h30);
      return (r == 10) ? CH_DOT : CH_DASH;
   endfunction

   function automatic logic [7:0] any_but_lf();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CH_LF) ? CH_SPACE : b;
   endfunction

   // Mostly well-formed key:value lines with random content; the rest noise, comment lines or damage.
   task automatic send_random_line();
      logic [7:0] text[$];
      logic [7:0] b;
      int shape;
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
      end else if (shape < 14) begin
         repeat ($urandom_range(0, 2)) text.push_back(blank_char());
         text.push_back(CH_HASH);
         repeat ($urandom_range(0, 5)) text.push_back(any_but_lf());
      end else begin
         repeat ($urandom_range(0, 1)) text.push_back(blank_char());
         repeat ($urandom_range(1, 6)) text.push_back(name_char());
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(blank_char());
         text.push_back(CH_COLON);
         if ($urandom_range(0, 2) == 0)
            text.push_back(blank_char());
         case ($urandom_range(0, 5))
            0, 1: repeat ($urandom_range(1, 6)) text.push_back(num_char());
            2: begin
               repeat ($urandom_range(1, 6)) begin
                  b = 8'($urandom_range(8'h21, 8'hFF));
                  text.push_back(b == CH_HASH ? 8'h2B : b);
               end
            end
            3, 4: begin
               text.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 3) == 0)
                     text.push_back(CH_BACKSLASH);
                  text.push_back(any_but_lf());
               end
               // sometimes leave the quote open
               if ($urandom_range(0, 7) != 0)
                  text.push_back(CH_QUOTE);
            end
            default: ;   // empty value
         endcase
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text.push_back(blank_char());
         if ($urandom_range(0, 3) == 0) begin
            text.push_back(CH_HASH);
            repeat ($urandom_range(0, 5)) text.push_back(any_but_lf());
         end
         // occasional single-byte damage
         if ($urandom_range(0, 9) == 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      foreach (text[i])
         send_beat(text[i], 1'b0);
      // close with a newline mostly, else end of text with a don't-care byte
      if ($urandom_range(0, 9) != 0)
         send_beat(CH_LF, 1'b0);
      else
         send_beat(8'($urandom_range(0, 255)), 1'b1);
      // end of text with no line open must produce nothing
      if ($urandom_range(0, 9) == 0)
         send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      send_beat(8'h00, 1'b1);            // end of text, nothing open
      send_text("\n");                   // blank line -> no key
      send_text("Z9:-1.5\n");            // leading dash then dot -> double
      // escaped backslash stays in escape, escaped quote, escaped 0xFF, then
      // end of text while still inside an escape -> accepted
      send_text("z\t:\"\\\\\"\\");
      send_beat(8'hFF, 1'b0);
      send_beat(CH_BACKSLASH, 1'b0);
      send_beat(8'hA5, 1'b1);
      send_text("a:\"\n");               // line ends right after the opening quote
      send_beat(8'h00, 1'b0);            // NUL where a key should start
      send_text("\n");
      send_text("#c\n");                 // comment only
   endtask

   task automatic test_drain_pause();
      repeat (20) send_random_line();
      wait_drain();
      repeat (20) send_random_line();
   endtask

   task automatic test_random_traffic(input int beats);
      int stop_at;
      stop_at = sent_beats + beats;
      while (sent_beats < stop_at) send_random_line();
   endtask

   task automatic test_back_to_back(input int beats);
      int stop_at;
      send_idle = 1'b0;
      take_idle = 1'b0;
      stop_at   = sent_beats + beats;
      while (sent_beats < stop_at) send_random_line();
      send_idle = 1'b1;
      take_idle = 1'b1;
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      int kinds;
      clear_line();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_drain_pause();
      test_random_traffic(450);
      test_back_to_back(300);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_items.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds = 0;
      foreach (status_tally[i])
         if (status_tally[i] > 0) kinds++;
      $display("Sent %0d text beats and checked %0d output beats in %0d cycles.",
               sent_beats, checked_beats, cycle_count);
      $display("Closed %0d lines covering %0d of 8 line statuses; %0d mismatches.",
               lines_closed, kinds, mismatches);
      if (mismatches == 0 && pending_items.size() == 0)
         $display("key_value_line_parser regression: pass");
      else
         $display("key_value_line_parser regression: fail");
      $finish;
   end

endmodule
